// File: sv/wh_pkg.sv
package wh_pkg;

   localparam int BIN_COUNT  = 1024;
   localparam int BIN_AW     = $clog2(BIN_COUNT);
   localparam int BIN_W      = 10;
   localparam int WEIGHT_W   = 16;
   localparam int CONTENT_W  = 40;
   localparam int ERROR_W    = 32;
   localparam int RADICAND_W = 2 * ERROR_W;

   localparam logic signed [CONTENT_W-1:0] CONTENT_MAX = {1'b0, {(CONTENT_W-1){1'b1}}};
   localparam logic signed [CONTENT_W-1:0] CONTENT_MIN = {1'b1, {(CONTENT_W-1){1'b0}}};

   typedef enum logic [1:0] {
      FUNC_FILL  = 2'd0,
      FUNC_QUICK = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_ROOT,
      ST_DONE
   } state_type;

   function automatic logic [BIN_AW-1:0] to_addr(input logic [BIN_W-1:0] b);
      logic [BIN_AW+BIN_W-1:0] wide;
      wide = {{BIN_AW{1'b0}}, b};
      return wide[BIN_AW-1:0];
   endfunction

   function automatic logic in_range(input logic [BIN_W-1:0] b);
      return (32'(b) < BIN_COUNT);
   endfunction

endpackage

// File: sv/wh_ram.sv
module wh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/wh_sqrt.sv
module wh_sqrt
   import wh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [RADICAND_W-1:0] radicand,
   output logic                  done,
   output logic [ERROR_W-1:0]    root
);

   localparam int REM_W = ERROR_W + 1;
   localparam int CNT_W = $clog2(ERROR_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [RADICAND_W-1:0] val_ff, val_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ERROR_W-1:0]    root_ff, root_in;

   logic [REM_W+1:0] rem_sh;
   logic [REM_W+1:0] trial;
   logic [REM_W+1:0] diff;

   always_comb begin
      rem_sh  = {rem_ff, val_ff[RADICAND_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = rem_sh - trial;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in = {val_ff[RADICAND_W-3:0], 2'b00};
         cnt_in = cnt_ff + 1'b1;
         if (rem_sh >= trial) begin
            rem_in  = diff[REM_W-1:0];
            root_in = {root_ff[ERROR_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_W-1:0];
            root_in = {root_ff[ERROR_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(ERROR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: sv/weighted_histogram_fill.sv
// Fill goes through the read, square, root and done states; quick fill and read go
// through read and done; an out-of-range bin goes straight to done. One item in flight.
// A fill reads memory, squares, runs the 32-step bit-serial square root and writes.
// Reset is synchronous; after it, both bin memories are zeroed in one pass over all
// 1024 entries, one entry per cycle, with req_stall high. Clear reuses that pass.
module weighted_histogram_fill
   import wh_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_func,
   input  logic [BIN_W-1:0]            req_bin,
   input  logic signed [WEIGHT_W-1:0]  req_weight,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [CONTENT_W-1:0] rsp_content,
   output logic [ERROR_W-1:0]          rsp_uncertainty,
   output logic                        rsp_saturated
);

   state_type state_ff, state_in;

   logic [BIN_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   func_type                    func_ff;
   logic [BIN_AW-1:0]           bin_ff;
   logic signed [WEIGHT_W-1:0]  weight_ff;
   logic                        hit_ff;
   logic signed [CONTENT_W-1:0] content_ff;
   logic [ERROR_W-1:0]          error_ff;
   logic                        sat_ff;
   logic [RADICAND_W-1:0]       sq_e_ff;
   logic [2*WEIGHT_W-1:0]       sq_w_ff;

   logic signed [CONTENT_W-1:0] rsp_content_ff;
   logic [ERROR_W-1:0]          rsp_uncertainty_ff;
   logic                        rsp_saturated_ff;

   logic                  accept;
   logic                  slot_free;
   logic                  clr_last;
   logic                  we_content;
   logic                  we_error;
   logic                  rsp_load;
   logic [BIN_AW-1:0]     wr_addr;
   logic [CONTENT_W-1:0]  wr_content;
   logic [ERROR_W-1:0]    wr_error;
   logic [CONTENT_W-1:0]  rd_content;
   logic [ERROR_W-1:0]    rd_error;
   logic                  sqrt_start;
   logic                  sqrt_done;
   logic [ERROR_W-1:0]    root_val;
   logic [RADICAND_W-1:0] radicand;

   logic signed [CONTENT_W:0]   sum;
   logic signed [CONTENT_W-1:0] sum_clip;
   logic                        sum_sat;
   logic [WEIGHT_W-1:0]         abs_w;

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign clr_last  = (clr_cnt_ff == BIN_AW'(BIN_COUNT - 1));

   wh_ram #(.WIDTH(CONTENT_W), .DEPTH(BIN_COUNT)) u_content_ram (
      .clock   (clock),
      .wr_en   (we_content),
      .wr_addr (wr_addr),
      .wr_data (wr_content),
      .rd_addr (to_addr(req_bin)),
      .rd_data (rd_content)
   );

   wh_ram #(.WIDTH(ERROR_W), .DEPTH(BIN_COUNT)) u_error_ram (
      .clock   (clock),
      .wr_en   (we_error),
      .wr_addr (wr_addr),
      .wr_data (wr_error),
      .rd_addr (to_addr(req_bin)),
      .rd_data (rd_error)
   );

   assign radicand = sq_e_ff + {{(RADICAND_W-2*WEIGHT_W){1'b0}}, sq_w_ff};

   wh_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (root_val)
   );

   always_comb begin
      sum = {rd_content[CONTENT_W-1], rd_content} + (CONTENT_W+1)'(weight_ff);
      sum_sat = 1'b0;
      sum_clip = sum[CONTENT_W-1:0];
      if (sum[CONTENT_W:CONTENT_W-1] == 2'b01) begin
         sum_clip = CONTENT_MAX;
         sum_sat  = 1'b1;
      end else if (sum[CONTENT_W:CONTENT_W-1] == 2'b10) begin
         sum_clip = CONTENT_MIN;
         sum_sat  = 1'b1;
      end
      abs_w = weight_ff[WEIGHT_W-1] ? WEIGHT_W'(-weight_ff) : weight_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (func_type'(req_func) == FUNC_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (in_range(req_bin)) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            state_in = (func_ff == FUNC_FILL) ? ST_SQUARE : ST_DONE;
         end
         ST_SQUARE: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      we_content = 1'b0;
      we_error   = 1'b0;
      wr_addr    = bin_ff;
      wr_content = content_ff;
      wr_error   = error_ff;
      sqrt_start = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            we_content = 1'b1;
            we_error   = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_content = '0;
            wr_error   = '0;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_SQUARE: begin
            sqrt_start = 1'b1;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_load   = 1'b1;
               we_content = hit_ff && (func_ff == FUNC_FILL || func_ff == FUNC_QUICK);
               we_error   = hit_ff && (func_ff == FUNC_FILL);
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      clr_rsp_in = clr_rsp_ff;
      if (state_ff == ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_last) begin
            clr_cnt_in = '0;
            clr_rsp_in = 1'b0;
         end
      end else if (accept && func_type'(req_func) == FUNC_CLEAR) begin
         clr_rsp_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff    <= func_type'(req_func);
         bin_ff     <= to_addr(req_bin);
         weight_ff  <= req_weight;
         hit_ff     <= in_range(req_bin) && (func_type'(req_func) != FUNC_CLEAR);
         content_ff <= '0;
         error_ff   <= '0;
         sat_ff     <= 1'b0;
      end
      if (state_ff == ST_READ) begin
         error_ff <= rd_error;
         sq_e_ff  <= rd_error * rd_error;
         sq_w_ff  <= abs_w * abs_w;
         if (func_ff == FUNC_READ) begin
            content_ff <= rd_content;
         end else begin
            content_ff <= sum_clip;
            sat_ff     <= sum_sat;
         end
      end
      if (state_ff == ST_ROOT && sqrt_done) begin
         error_ff <= root_val;
      end
      if (rsp_load) begin
         rsp_content_ff     <= content_ff;
         rsp_uncertainty_ff <= error_ff;
         rsp_saturated_ff   <= sat_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_content     = rsp_content_ff;
   assign rsp_uncertainty = rsp_uncertainty_ff;
   assign rsp_saturated   = rsp_saturated_ff;

   a_root_done_in_root: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == ST_ROOT)
      else $error("root done outside root wait");

   a_clear_writes_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> we_content && wr_content == '0 && wr_error == '0)
      else $error("clear pass writes nonzero data");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_content == CONTENT_MAX || rsp_content == CONTENT_MIN)
      else $error("saturated flag without clipped content");

   a_no_write_in_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !we_content && !we_error)
      else $error("memory write while idle");

endmodule
